@@ rtl/easat_pkg.sv @@
// shared types and constants for the expiring address slot table
// no dependencies
`default_nettype none

package easat_pkg;

    localparam int TIMEOUT_W = 20;
    localparam int TICK_W    = 32;
    localparam int CMD_W     = 3;
    localparam int SLOT_W    = 8;

    localparam logic [CMD_W-1:0] CMD_ADD        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TOUCH      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_EXPIRE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_TO    = 3'd5;

    // a cleared slot counts as last accessed at this tick
    localparam logic signed [TICK_W+1:0] CLEARED_TICK = -34'sd1000;

    typedef struct packed {
        logic expired;
        logic hit;
    } slot_status_t;

endpackage

`default_nettype wire

@@ rtl/easat_mem.sv @@
// slot table memory, one write port and one registered read port
// no dependencies
`default_nettype none

module easat_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 136
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/easat_eval.sv @@
// expiry and address match check for one slot entry
// depends on easat_pkg
`default_nettype none

module easat_eval
    import easat_pkg::*;
#(
    parameter int ADDRESS_BITS = 48
) (
    input  logic                    used,
    input  logic [ADDRESS_BITS-1:0] entry_addr,
    input  logic [ADDRESS_BITS-1:0] key_addr,
    input  logic [TIMEOUT_W-1:0]    timeout,
    input  logic                    expire_on,
    input  logic [TICK_W-1:0]       expire_at,
    input  logic [TICK_W-1:0]       last_access,
    input  logic                    cleared,
    input  logic [TICK_W-1:0]       now,
    output slot_status_t            status
);

    logic signed [TICK_W+1:0] last_s;
    logic signed [TICK_W+1:0] idle_end;
    logic signed [TICK_W+1:0] now_s;
    logic                     idle_hit;
    logic                     abs_hit;

    always_comb
    begin
        last_s   = cleared ? CLEARED_TICK : signed'({2'b00, last_access});
        idle_end = last_s + signed'({{(TICK_W + 2 - TIMEOUT_W){1'b0}}, timeout});
        now_s    = signed'({2'b00, now});
        idle_hit = (timeout != '0) && (idle_end < now_s);
        abs_hit  = expire_on && (expire_at < now);
        status.expired = idle_hit || abs_hit;
        status.hit     = used && (entry_addr == key_addr);
    end

endmodule

`default_nettype wire

@@ rtl/expiring_address_slot_table.sv @@
// Expiring address slot table: one command per transaction, one result per
// command. Add, find and remove read slots from the table memory in order,
// one slot per cycle (add always covers all SLOTS, find and remove cover the
// high-water count). A remove of the top slot then walks down over expired
// slots, reading and then checking each one. After reset the block clears the
// memory before it takes the first command.
// depends on easat_pkg, easat_mem, easat_eval
`default_nettype none

module expiring_address_slot_table
    import easat_pkg::*;
#(
    parameter int SLOTS        = 256,
    parameter int ADDRESS_BITS = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [CMD_W-1:0]        command,
    input  logic [ADDRESS_BITS-1:0] peer_address,
    input  logic [TICK_W-1:0]       now_ticks,
    input  logic [TICK_W-1:0]       expire_at,
    input  logic                    expire_on,
    input  logic [TIMEOUT_W-1:0]    idle_timeout,
    input  logic [SLOT_W-1:0]       slot_in,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    success,
    output logic [SLOT_W-1:0]       slot_out,
    output logic [TIMEOUT_W-1:0]    timeout_out
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef struct packed {
        logic                    used;
        logic [ADDRESS_BITS-1:0] addr;
        logic [TIMEOUT_W-1:0]    timeout;
        logic                    eon;
        logic [TICK_W-1:0]       eat;
        logic [TICK_W-1:0]       last;
        logic                    cleared;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_WALK_RD,
        S_WALK_CHK,
        S_SLOT_RD,
        S_SLOT_DO,
        S_RESP
    } state_t;

    state_t                  state_reg;
    logic [CMD_W-1:0]        cmd_reg;
    logic [ADDRESS_BITS-1:0] addr_reg;
    logic [TICK_W-1:0]       now_reg;
    logic [TICK_W-1:0]       eat_reg;
    logic                    eon_reg;
    logic [TIMEOUT_W-1:0]    to_reg;
    logic [IDX_W-1:0]        sin_reg;
    logic [CNT_W-1:0]        hwc_reg;
    logic [CNT_W-1:0]        issue_reg;
    logic [CNT_W-1:0]        limit_reg;
    logic                    chk_vld_reg;
    logic [IDX_W-1:0]        chk_idx_reg;
    logic                    match_found_reg;
    logic [IDX_W-1:0]        match_idx_reg;
    entry_t                  match_entry_reg;
    logic                    free_found_reg;
    logic [IDX_W-1:0]        free_idx_reg;
    logic [CNT_W-1:0]        walk_k_reg;
    logic                    res_ok_reg;
    logic [IDX_W-1:0]        res_slot_reg;
    logic [TIMEOUT_W-1:0]    res_tout_reg;
    logic                    out_valid_reg;
    logic                    success_reg;
    logic [SLOT_W-1:0]       slot_out_reg;
    logic [TIMEOUT_W-1:0]    timeout_out_reg;

    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    entry_t                  mem_wdata;
    logic [IDX_W-1:0]        mem_raddr;
    logic [ENTRY_W-1:0]      mem_rdata;
    entry_t                  rd_entry;
    slot_status_t            rd_status;

    logic [CNT_W+SLOT_W-1:0] sin_wide;
    logic                    sin_in_range;
    logic                    chk_in_cnt;
    logic                    live;
    logic [IDX_W-1:0]        add_idx;
    logic [IDX_W-1:0]        walk_idx;
    logic [IDX_W+SLOT_W-1:0] res_slot_wide;
    entry_t                  new_entry;
    entry_t                  clear_entry;
    entry_t                  reset_entry;

    assign rd_entry      = entry_t'(mem_rdata);
    assign sin_wide      = {{CNT_W{1'b0}}, slot_in};
    assign sin_in_range  = sin_wide < {{SLOT_W{1'b0}}, hwc_reg};
    assign chk_in_cnt    = CNT_W'(chk_idx_reg) < hwc_reg;
    assign live          = rd_status.hit && !rd_status.expired;
    assign add_idx       = match_found_reg ? match_idx_reg : free_idx_reg;
    assign walk_idx      = IDX_W'(walk_k_reg - CNT_W'(1));
    assign res_slot_wide = {{SLOT_W{1'b0}}, res_slot_reg};

    easat_mem #(
        .DEPTH (SLOTS),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (ENTRY_W'(mem_wdata)),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    easat_eval #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_eval (
        .used        (rd_entry.used),
        .entry_addr  (rd_entry.addr),
        .key_addr    (addr_reg),
        .timeout     (rd_entry.timeout),
        .expire_on   (rd_entry.eon),
        .expire_at   (rd_entry.eat),
        .last_access (rd_entry.last),
        .cleared     (rd_entry.cleared),
        .now         (now_reg),
        .status      (rd_status)
    );

    always_comb
    begin
        reset_entry         = '0;
        reset_entry.cleared = 1'b1;

        new_entry         = '0;
        new_entry.used    = 1'b1;
        new_entry.addr    = addr_reg;
        new_entry.timeout = to_reg;
        new_entry.eon     = eon_reg;
        new_entry.eat     = eat_reg;
        new_entry.last    = now_reg;

        clear_entry         = '0;
        clear_entry.timeout = match_entry_reg.timeout;
        clear_entry.cleared = 1'b1;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = issue_reg[IDX_W-1:0];
                mem_wdata = reset_entry;
            end
            S_SCAN:
            begin
                mem_raddr = issue_reg[IDX_W-1:0];
            end
            S_FINISH:
            begin
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        mem_we    = match_found_reg || free_found_reg;
                        mem_waddr = add_idx;
                        mem_wdata = new_entry;
                    end
                    CMD_FIND:
                    begin
                        mem_we            = match_found_reg;
                        mem_waddr         = match_idx_reg;
                        mem_wdata         = match_entry_reg;
                        mem_wdata.last    = now_reg;
                        mem_wdata.cleared = 1'b0;
                    end
                    default:
                    begin
                        mem_we    = match_found_reg;
                        mem_waddr = match_idx_reg;
                        mem_wdata = clear_entry;
                    end
                endcase
            end
            S_WALK_RD:
            begin
                mem_raddr = walk_idx;
            end
            S_WALK_CHK:
            begin
                mem_we         = rd_status.expired;
                mem_waddr      = walk_idx;
                mem_wdata      = rd_entry;
                mem_wdata.used = 1'b0;
            end
            S_SLOT_RD:
            begin
                mem_raddr = sin_reg;
            end
            S_SLOT_DO:
            begin
                mem_waddr = sin_reg;
                mem_wdata = rd_entry;
                case (cmd_reg)
                    CMD_TOUCH:
                    begin
                        mem_we            = rd_status.hit;
                        mem_wdata.last    = now_reg;
                        mem_wdata.cleared = 1'b0;
                    end
                    CMD_SET_EXPIRE:
                    begin
                        mem_we        = 1'b1;
                        mem_wdata.eon = eon_reg;
                        mem_wdata.eat = eat_reg;
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            issue_reg       <= '0;
            hwc_reg         <= '0;
            chk_vld_reg     <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_RESP))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    issue_reg <= issue_reg + CNT_W'(1);
                    if (issue_reg == CNT_W'(SLOTS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg         <= command;
                        addr_reg        <= peer_address;
                        now_reg         <= now_ticks;
                        eat_reg         <= expire_at;
                        eon_reg         <= expire_on;
                        to_reg          <= idle_timeout;
                        sin_reg         <= sin_wide[IDX_W-1:0];
                        res_ok_reg      <= 1'b0;
                        res_slot_reg    <= '0;
                        res_tout_reg    <= '0;
                        issue_reg       <= '0;
                        chk_vld_reg     <= 1'b0;
                        match_found_reg <= 1'b0;
                        free_found_reg  <= 1'b0;
                        limit_reg       <= (command == CMD_ADD) ? CNT_W'(SLOTS) : hwc_reg;
                        unique case (command) inside
                            CMD_ADD, CMD_REMOVE, CMD_FIND:
                            begin
                                state_reg <= S_SCAN;
                            end
                            CMD_TOUCH, CMD_SET_EXPIRE, CMD_READ_TO:
                            begin
                                state_reg <= sin_in_range ? S_SLOT_RD : S_RESP;
                            end
                            default:
                            begin
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (issue_reg < limit_reg)
                    begin
                        issue_reg   <= issue_reg + CNT_W'(1);
                        chk_vld_reg <= 1'b1;
                        chk_idx_reg <= issue_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        chk_vld_reg <= 1'b0;
                    end
                    if (chk_vld_reg)
                    begin
                        case (cmd_reg)
                            CMD_ADD:
                            begin
                                if (chk_in_cnt && live && !match_found_reg)
                                begin
                                    match_found_reg <= 1'b1;
                                    match_idx_reg   <= chk_idx_reg;
                                end
                                if ((!rd_entry.used || rd_status.expired) && !free_found_reg)
                                begin
                                    free_found_reg <= 1'b1;
                                    free_idx_reg   <= chk_idx_reg;
                                end
                            end
                            CMD_FIND:
                            begin
                                if (chk_in_cnt && live && !match_found_reg)
                                begin
                                    match_found_reg <= 1'b1;
                                    match_idx_reg   <= chk_idx_reg;
                                    match_entry_reg <= rd_entry;
                                end
                            end
                            default:
                            begin
                                if (chk_in_cnt && rd_status.hit && !match_found_reg)
                                begin
                                    match_found_reg <= 1'b1;
                                    match_idx_reg   <= chk_idx_reg;
                                    match_entry_reg <= rd_entry;
                                end
                            end
                        endcase
                    end
                    if (!chk_vld_reg && (issue_reg == limit_reg))
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    state_reg <= S_RESP;
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            res_ok_reg   <= match_found_reg || free_found_reg;
                            res_slot_reg <= add_idx;
                            if ((match_found_reg || free_found_reg) &&
                                (CNT_W'(add_idx) + CNT_W'(1) > hwc_reg))
                            begin
                                hwc_reg <= CNT_W'(add_idx) + CNT_W'(1);
                            end
                        end
                        CMD_FIND:
                        begin
                            res_ok_reg   <= match_found_reg;
                            res_slot_reg <= match_idx_reg;
                        end
                        default:
                        begin
                            res_ok_reg   <= match_found_reg;
                            res_slot_reg <= match_idx_reg;
                            if (match_found_reg &&
                                (CNT_W'(match_idx_reg) + CNT_W'(1) == hwc_reg))
                            begin
                                walk_k_reg <= CNT_W'(match_idx_reg);
                                state_reg  <= S_WALK_RD;
                            end
                        end
                    endcase
                end
                S_WALK_RD:
                begin
                    if (walk_k_reg == '0)
                    begin
                        hwc_reg   <= '0;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_WALK_CHK;
                    end
                end
                S_WALK_CHK:
                begin
                    if (rd_status.expired)
                    begin
                        walk_k_reg <= walk_k_reg - CNT_W'(1);
                        state_reg  <= S_WALK_RD;
                    end
                    else
                    begin
                        hwc_reg   <= walk_k_reg;
                        state_reg <= S_RESP;
                    end
                end
                S_SLOT_RD:
                begin
                    state_reg <= S_SLOT_DO;
                end
                S_SLOT_DO:
                begin
                    state_reg    <= S_RESP;
                    res_slot_reg <= sin_reg;
                    case (cmd_reg)
                        CMD_TOUCH:
                        begin
                            res_ok_reg <= rd_status.hit;
                        end
                        CMD_READ_TO:
                        begin
                            res_ok_reg   <= 1'b1;
                            res_tout_reg <= rd_entry.timeout;
                        end
                        default:
                        begin
                            res_ok_reg <= 1'b1;
                        end
                    endcase
                end
                S_RESP:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg   <= 1'b1;
                        success_reg     <= res_ok_reg;
                        slot_out_reg    <= res_ok_reg ? res_slot_wide[SLOT_W-1:0] : '0;
                        timeout_out_reg <= res_ok_reg ? res_tout_reg : '0;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign success     = success_reg;
    assign slot_out    = slot_out_reg;
    assign timeout_out = timeout_out_reg;

endmodule

`default_nettype wire

@@ rtl/easat_checker.sv @@
// port-level checks for the expiring address slot table and its bind
// depends on easat_pkg and expiring_address_slot_table
`default_nettype none

module easat_checker
    import easat_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic                 success,
    input logic [SLOT_W-1:0]    slot_out,
    input logic [TIMEOUT_W-1:0] timeout_out
);

    // one transaction in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a command is still in flight");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !success) |-> (slot_out == '0 && timeout_out == '0))
        else $error("failed result carries nonzero fields");

    a_timeout_success: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && timeout_out != '0) |-> success)
        else $error("timeout reported without success");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
        (out_valid && $stable(success) && $stable(slot_out) && $stable(timeout_out)))
        else $error("stalled result changed");

endmodule

bind expiring_address_slot_table easat_checker u_easat_checker (.*);

`default_nettype wire

@@ tb/tb_expiring_address_slot_table.sv @@
// testbench for the expiring address slot table: directed commands, a full-table fill under
// a long output hold-off, a drain with expiry walk-down, then random command mixes
// depends on easat_pkg and expiring_address_slot_table
`default_nettype none

module tb_expiring_address_slot_table;
    import easat_pkg::*;

    localparam int NSLOTS = 256;
    localparam int ADDR_W = 48;
    localparam longint CLEARED_AT = -1000;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

    typedef struct {
        logic                 ok;
        logic [SLOT_W-1:0]    slot;
        logic [TIMEOUT_W-1:0] tout;
    } slot_answer_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [CMD_W-1:0]        command;
    logic [ADDR_W-1:0]       peer_address;
    logic [TICK_W-1:0]       now_ticks;
    logic [TICK_W-1:0]       expire_at;
    logic                    expire_on;
    logic [TIMEOUT_W-1:0]    idle_timeout;
    logic [SLOT_W-1:0]       slot_in;
    logic                    out_valid;
    logic                    out_stall;
    logic                    success;
    logic [SLOT_W-1:0]       slot_out;
    logic [TIMEOUT_W-1:0]    timeout_out;

    // predicted table contents
    logic                 tbl_used [NSLOTS];
    logic [ADDR_W-1:0]    tbl_addr [NSLOTS];
    logic [TIMEOUT_W-1:0] tbl_timeout [NSLOTS];
    logic                 tbl_exp_on [NSLOTS];
    logic [TICK_W-1:0]    tbl_exp_at [NSLOTS];
    logic [TICK_W-1:0]    tbl_last [NSLOTS];
    logic                 tbl_cleared [NSLOTS];
    int                   high_water;

    slot_answer_t     pending_answers[$];
    logic [ADDR_W-1:0] peer_pool [16];
    logic [ADDR_W-1:0] fill_peers [NSLOTS];
    logic [TICK_W-1:0] tick_now;
    int burst_left;
    int errors;
    int sent_count;
    int checked_count;
    int hits_seen;
    int idle_cycles;
    int stall_phase;
    logic hold_req;

    expiring_address_slot_table #(.SLOTS(NSLOTS), .ADDRESS_BITS(ADDR_W)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .peer_address(peer_address), .now_ticks(now_ticks),
        .expire_at(expire_at), .expire_on(expire_on), .idle_timeout(idle_timeout),
        .slot_in(slot_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .success(success), .slot_out(slot_out), .timeout_out(timeout_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic slot_expired(input int s, input longint nw);
        longint last;
        last = tbl_cleared[s] ? CLEARED_AT : longint'(tbl_last[s]);
        if (tbl_timeout[s] != 0 && last + longint'(tbl_timeout[s]) < nw)
            return 1'b1;
        return tbl_exp_on[s] && longint'(tbl_exp_at[s]) < nw;
    endfunction

    task automatic table_predict(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                                 input logic [TICK_W-1:0] nw, input logic [TICK_W-1:0] ea,
                                 input logic eo, input logic [TIMEOUT_W-1:0] it,
                                 input logic [SLOT_W-1:0] si, output slot_answer_t ans);
        longint t;
        int cnt;
        int k;
        t = longint'(nw);
        cnt = high_water > NSLOTS ? NSLOTS : high_water;
        ans.ok = 1'b0;
        ans.slot = '0;
        ans.tout = '0;
        case (c)
            CMD_ADD:
            begin
                for (int i = 0; i < cnt && !ans.ok; i++)
                    if (tbl_used[i] && tbl_addr[i] == a && !slot_expired(i, t))
                    begin
                        tbl_timeout[i] = it; tbl_exp_on[i] = eo; tbl_exp_at[i] = ea;
                        tbl_last[i] = nw; tbl_cleared[i] = 1'b0;
                        ans.ok = 1'b1; ans.slot = SLOT_W'(i);
                    end
                for (int i = 0; i < NSLOTS && !ans.ok; i++)
                    if (!tbl_used[i] || slot_expired(i, t))
                    begin
                        tbl_timeout[i] = it; tbl_exp_on[i] = eo; tbl_exp_at[i] = ea;
                        tbl_last[i] = nw; tbl_cleared[i] = 1'b0;
                        tbl_used[i] = 1'b1; tbl_addr[i] = a;
                        if (i + 1 > high_water)
                            high_water = i + 1;
                        ans.ok = 1'b1; ans.slot = SLOT_W'(i);
                    end
            end
            CMD_REMOVE:
            begin
                for (int i = 0; i < cnt && !ans.ok; i++)
                    if (tbl_used[i] && tbl_addr[i] == a)
                    begin
                        tbl_exp_on[i] = 1'b0; tbl_exp_at[i] = '0; tbl_last[i] = '0;
                        tbl_cleared[i] = 1'b1; tbl_used[i] = 1'b0; tbl_addr[i] = '0;
                        ans.ok = 1'b1; ans.slot = SLOT_W'(i);
                        if (i + 1 == cnt)
                        begin
                            k = i;
                            while (k > 0 && slot_expired(k - 1, t))
                            begin
                                tbl_used[k - 1] = 1'b0;
                                k--;
                            end
                            high_water = k;
                        end
                    end
            end
            CMD_FIND:
            begin
                for (int i = 0; i < cnt && !ans.ok; i++)
                    if (tbl_used[i] && tbl_addr[i] == a && !slot_expired(i, t))
                    begin
                        tbl_last[i] = nw; tbl_cleared[i] = 1'b0;
                        ans.ok = 1'b1; ans.slot = SLOT_W'(i);
                    end
            end
            CMD_TOUCH:
            begin
                if (si < cnt && tbl_used[si] && tbl_addr[si] == a)
                begin
                    tbl_last[si] = nw; tbl_cleared[si] = 1'b0;
                    ans.ok = 1'b1; ans.slot = si;
                end
            end
            CMD_SET_EXPIRE:
            begin
                if (si < cnt)
                begin
                    tbl_exp_on[si] = eo; tbl_exp_at[si] = ea;
                    ans.ok = 1'b1; ans.slot = si;
                end
            end
            CMD_READ_TO:
            begin
                if (si < cnt)
                begin
                    ans.tout = tbl_timeout[si];
                    ans.ok = 1'b1; ans.slot = si;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                             input logic [TICK_W-1:0] nw, input logic [TICK_W-1:0] ea,
                             input logic eo, input logic [TIMEOUT_W-1:0] it,
                             input logic [SLOT_W-1:0] si);
        slot_answer_t ans;
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        command = c; peer_address = a; now_ticks = nw; expire_at = ea;
        expire_on = eo; idle_timeout = it; slot_in = si;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        table_predict(c, a, nw, ea, eo, it, si, ans);
        pending_answers.push_back(ans);
        sent_count++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic test_directed();
        logic [ADDR_W-1:0] pa;
        logic [ADDR_W-1:0] pb;
        logic [ADDR_W-1:0] pd;
        pa = {ADDR_W{1'b1}};
        pb = 48'h0123_4567_89AB;
        pd = 48'h8000_0000_0001;
        send_item(CMD_ADD, pa, 1000, 0, 0, 0, 0);
        send_item(CMD_ADD, '0, 1000, 0, 0, 0, 0);
        send_item(CMD_FIND, pa, 1000, 0, 0, 0, 0);
        send_item(CMD_FIND, pb, 1000, 0, 0, 0, 0);
        send_item(CMD_TOUCH, pa, 1001, 0, 0, 0, 0);
        send_item(CMD_TOUCH, pb, 1001, 0, 0, 0, 0);
        send_item(CMD_TOUCH, pa, 1001, 0, 0, 0, 200);
        send_item(CMD_SET_EXPIRE, '0, 1002, 5000, 1, 0, 1);
        send_item(CMD_READ_TO, '0, 1002, 0, 0, 0, 0);
        send_item(CMD_READ_TO, '0, 1002, 0, 0, 0, 255);
        send_item(CMD_UNUSED_A, pa, 1002, 0, 1, 7, 0);
        send_item(CMD_UNUSED_B, pa, 1002, 0, 1, 7, 0);
        send_item(CMD_ADD, pd, 1000, 32'hFFFF_FFFF, 0, 20'hFFFFF, 0);
        send_item(CMD_READ_TO, '0, 1003, 0, 0, 0, 2);
        send_item(CMD_ADD, pb, 1000, 0, 0, 5, 0);
        send_item(CMD_FIND, pb, 1100, 0, 0, 0, 0);
        send_item(CMD_ADD, pb, 1100, 0, 0, 5, 0);
        send_item(CMD_FIND, '0, 6000, 0, 0, 0, 0);
        send_item(CMD_REMOVE, pa, 6000, 0, 0, 0, 0);
        send_item(CMD_REMOVE, pa, 6000, 0, 0, 0, 0);
        send_item(CMD_REMOVE, pb, 6000, 0, 0, 0, 0);
        send_item(CMD_ADD, pa, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 20'hFFFFF, 8'hFF);
        send_item(CMD_ADD, pb, 32'hFFFF_FFFF, 0, 1, 1, 0);
    endtask

    task automatic test_fill_under_hold();
        tick_now = 10000;
        for (int i = 0; i < NSLOTS; i++)
            fill_peers[i] = ADDR_W'({$urandom, $urandom});
        for (int i = 0; i < NSLOTS + 4; i++)
        begin
            if (i == 40)
                hold_req = 1'b1;
            send_item(CMD_ADD, fill_peers[i % NSLOTS] ^ (i >= NSLOTS ? 48'h1 : 48'h0),
                      tick_now, $urandom, 1'b0, 20'd0, 8'd0);
        end
    endtask

    task automatic test_drain_walkdown();
        tick_now = 20000;
        for (int s = 120; s <= 150; s++)
            send_item(CMD_SET_EXPIRE, '0, tick_now, 32'd5, 1'b1, 20'd0, SLOT_W'(s));
        for (int i = NSLOTS - 1; i >= 0; i--)
            send_item(CMD_REMOVE, fill_peers[i], tick_now, 0, 1'b0, 20'd0, 8'd0);
    endtask

    task automatic test_random_mix(input int n);
        logic [CMD_W-1:0]     c;
        logic [ADDR_W-1:0]    a;
        logic [TICK_W-1:0]    ea;
        logic [TIMEOUT_W-1:0] it;
        logic [SLOT_W-1:0]    si;
        logic                 eo;
        int r;
        for (int i = 0; i < 16; i++)
            peer_pool[i] = ADDR_W'({$urandom, $urandom});
        peer_pool[0] = '0;
        tick_now = 30000;
        for (int n_i = 0; n_i < n; n_i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30) c = CMD_ADD;
            else if (r < 45) c = CMD_REMOVE;
            else if (r < 65) c = CMD_FIND;
            else if (r < 75) c = CMD_TOUCH;
            else if (r < 85) c = CMD_SET_EXPIRE;
            else if (r < 95) c = CMD_READ_TO;
            else c = $urandom_range(0, 1) ? CMD_UNUSED_A : CMD_UNUSED_B;
            if ($urandom_range(0, 49) == 0)
                tick_now = $urandom;
            else
                tick_now = tick_now + $urandom_range(0, 20);
            a = $urandom_range(0, 9) == 0 ? ADDR_W'({$urandom, $urandom}) :
                peer_pool[$urandom_range(0, 15)];
            r = $urandom_range(0, 9);
            it = r < 7 ? TIMEOUT_W'($urandom_range(0, 60)) :
                 (r < 8 ? 20'd0 : TIMEOUT_W'($urandom));
            eo = 1'($urandom_range(0, 1));
            ea = $urandom_range(0, 4) == 0 ? $urandom : tick_now + $urandom_range(0, 80);
            si = $urandom_range(0, 6) == 0 ? SLOT_W'($urandom_range(0, 255)) :
                 SLOT_W'($urandom_range(0, 20));
            if (c == CMD_TOUCH && $urandom_range(0, 9) < 6)
                a = tbl_addr[si];
            send_item(c, a, tick_now, ea, eo, it, si);
        end
    endtask

    // output stall pattern, plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        stall_phase = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (4000) @(negedge clk);
                hold_req = 1'b0;
                out_stall = 1'b0;
            end
            else
            begin
                stall_phase++;
                case (stall_phase[11:10])
                    2'd0: out_stall = 1'b0;
                    2'd1: out_stall = $urandom_range(0, 3) == 0;
                    2'd2: out_stall = stall_phase[3];
                    default: out_stall = $urandom_range(0, 1);
                endcase
            end
        end
    end

    initial
    begin
        slot_answer_t exp_ans;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_answers.size() == 0)
                begin
                    $display("%0t: unexpected transaction success=%0d slot=%0d timeout=%0d",
                             $time, success, slot_out, timeout_out);
                    errors++;
                end
                else
                begin
                    exp_ans = pending_answers.pop_front();
                    checked_count++;
                    if (exp_ans.ok)
                        hits_seen++;
                    if (success !== exp_ans.ok)
                    begin
                        $display("%0t: success expected %0d actual %0d", $time, exp_ans.ok,
                                 success);
                        errors++;
                    end
                    if (slot_out !== exp_ans.slot)
                    begin
                        $display("%0t: slot_out expected %0d actual %0d", $time,
                                 exp_ans.slot, slot_out);
                        errors++;
                    end
                    if (timeout_out !== exp_ans.tout)
                    begin
                        $display("%0t: timeout_out expected %0d actual %0d", $time,
                                 exp_ans.tout, timeout_out);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout with %0d transactions outstanding", $time,
                         pending_answers.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = '0; peer_address = '0; now_ticks = '0; expire_at = '0;
        expire_on = 1'b0; idle_timeout = '0; slot_in = '0;
        hold_req = 1'b0;
        errors = 0; sent_count = 0; checked_count = 0; hits_seen = 0; burst_left = 0;
        high_water = 0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            tbl_used[i] = 1'b0; tbl_addr[i] = '0; tbl_timeout[i] = '0; tbl_exp_on[i] = 1'b0;
            tbl_exp_at[i] = '0; tbl_last[i] = '0; tbl_cleared[i] = 1'b1;
        end
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_fill_under_hold();
        test_drain_walkdown();
        test_random_mix(800);
        in_valid = 1'b0;
        wait (pending_answers.size() == 0);
        repeat (600) @(posedge clk);
        $display("covered %0d commands, %0d results checked, %0d successful", sent_count,
                 checked_count, hits_seen);
        $display("including full-table adds, expiry walk-down on remove and a long output hold");
        if (errors == 0 && pending_answers.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
